/* src/rgb_xyy_luminance_scaler_macros.svh */
// ---------------------------------------------------------------------------
// rgb_xyy_luminance_scaler_macros.svh
// Assertion macros shared by the luminance scaler RTL.
// ---------------------------------------------------------------------------
`ifndef RGB_XYY_LUMINANCE_SCALER_MACROS_SVH
`define RGB_XYY_LUMINANCE_SCALER_MACROS_SVH

// Same-cycle implication, checked on clk, held off while in reset.
`define RXLS_ASSERT_IMP(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rxls: same-cycle check failed");

// Next-cycle implication, checked on clk, held off while in reset.
`define RXLS_ASSERT_NXT(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rxls: next-cycle check failed");

`endif

/* src/rxls_pkg.sv */
// ---------------------------------------------------------------------------
// rxls_pkg
// Widths and matrix coefficients of the RGB / xyY luminance scaler.
// ---------------------------------------------------------------------------
`default_nettype none

package rxls_pkg;

    localparam int PIX_W      = 8;
    localparam int TDATA_W    = 3 * PIX_W;
    localparam int GAIN_W     = 9;
    localparam logic [GAIN_W-1:0] GAIN_RESET = 9'd51;

    localparam int COEF_W     = 17;   // signed Q2.14
    localparam int XYZ_W      = 23;   // forward X, Y, Z, 14 fraction bits
    localparam int SUM_W      = 24;   // X + Y + Z
    localparam int CHR_W      = 16;   // chromaticity Q0.16 after cap
    localparam int CHR_Q_W    = 17;   // raw chromaticity quotient
    localparam int REST_W     = 17;   // 1 - x - y
    localparam int LUM_W      = 16;   // Y in Q8.8
    localparam int LUMP_W     = LUM_W + GAIN_W;
    localparam int LUMS_W     = 17;   // scaled Y, Q9.8
    localparam int RATIO_W    = 24;   // Y / y, 8 fraction bits
    localparam int RB_W       = 25;   // rebuilt X, Y, Z
    localparam int PROD_W     = 43;
    localparam int ACC_W      = 45;
    localparam int OUT_SHIFT  = 22;

    localparam logic [13:0] FWD_M [3][3] = '{
        '{14'd6757, 14'd5859, 14'd2957},
        '{14'd3483, 14'd11718, 14'd1183},
        '{14'd316,  14'd1953, 14'd15573}
    };

    localparam logic signed [COEF_W-1:0] INV_M [3][3] = '{
        '{ 17'sd53092, -17'sd25184,  -17'sd8167},
        '{-17'sd15881,  17'sd30736,    17'sd682},
        '{   17'sd911,  -17'sd3342,  17'sd17321}
    };

endpackage

`default_nettype wire

/* src/rxls_pipe_div.sv */
// ---------------------------------------------------------------------------
// rxls_pipe_div
// Pipelined restoring divider, one quotient bit per register stage.
// ---------------------------------------------------------------------------
`default_nettype none

module rxls_pipe_div #(
    parameter int NUM_W  = rxls_pkg::XYZ_W + 16,
    parameter int DEN_W  = rxls_pkg::SUM_W,
    parameter int Q_W    = rxls_pkg::CHR_Q_W,
    parameter int SIDE_W = 1
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              adv,
    input  wire logic              in_valid,
    input  wire logic [NUM_W-1:0]  num,
    input  wire logic [DEN_W-1:0]  den,
    input  wire logic [SIDE_W-1:0] side_in,
    output logic                   out_valid,
    output logic [Q_W-1:0]         quo,
    output logic [SIDE_W-1:0]      side_out
);

    logic              v_reg    [Q_W];
    logic [DEN_W-1:0]  rem_reg  [Q_W];
    logic [Q_W-1:0]    low_reg  [Q_W];
    logic [Q_W-1:0]    q_reg    [Q_W];
    logic [DEN_W-1:0]  den_reg  [Q_W];
    logic [SIDE_W-1:0] side_reg [Q_W];

    for (genvar i = 0; i < Q_W; i++) begin : g_stage
        logic              v_in;
        logic [DEN_W-1:0]  rem_in;
        logic [Q_W-1:0]    low_in;
        logic [Q_W-1:0]    q_in;
        logic [DEN_W-1:0]  den_in;
        logic [SIDE_W-1:0] side_in_s;
        logic [DEN_W:0]    trial;
        logic              ge;
        logic [DEN_W-1:0]  rem_next;

        if (i == 0) begin : g_first
            // upper numerator bits seed the remainder; they stay below den
            assign v_in      = in_valid;
            assign rem_in    = DEN_W'(num >> Q_W);
            assign low_in    = num[Q_W-1:0];
            assign q_in      = '0;
            assign den_in    = den;
            assign side_in_s = side_in;
        end
        else begin : g_rest
            assign v_in      = v_reg[i-1];
            assign rem_in    = rem_reg[i-1];
            assign low_in    = low_reg[i-1];
            assign q_in      = q_reg[i-1];
            assign den_in    = den_reg[i-1];
            assign side_in_s = side_reg[i-1];
        end

        assign trial    = {rem_in, low_in[Q_W-1]};
        assign ge       = (trial >= {1'b0, den_in});
        assign rem_next = ge ? DEN_W'(trial - {1'b0, den_in}) : DEN_W'(trial);

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                v_reg[i] <= 1'b0;
            end
            else if (adv)
            begin
                v_reg[i] <= v_in;
            end
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                rem_reg[i]  <= rem_next;
                low_reg[i]  <= {low_in[Q_W-2:0], 1'b0};
                q_reg[i]    <= {q_in[Q_W-2:0], ge};
                den_reg[i]  <= den_in;
                side_reg[i] <= side_in_s;
            end
        end
    end

    assign out_valid = v_reg[Q_W-1];
    assign quo       = q_reg[Q_W-1];
    assign side_out  = side_reg[Q_W-1];

endmodule

`default_nettype wire

/* src/rxls_fwd_xform.sv */
// ---------------------------------------------------------------------------
// rxls_fwd_xform
// RGB to XYZ matrix, one register stage.
// ---------------------------------------------------------------------------
`default_nettype none

module rxls_fwd_xform (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        adv,
    input  wire logic                        in_valid,
    input  wire logic [rxls_pkg::TDATA_W-1:0] pix,
    output logic                             out_valid,
    output logic [rxls_pkg::XYZ_W-1:0]       x,
    output logic [rxls_pkg::XYZ_W-1:0]       y,
    output logic [rxls_pkg::XYZ_W-1:0]       z
);
    import rxls_pkg::*;

    logic                valid_reg;
    logic [XYZ_W-1:0]    xyz_reg  [3];
    logic [XYZ_W-1:0]    xyz_next [3];

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            xyz_next[i] = '0;
            for (int k = 0; k < 3; k++)
            begin
                xyz_next[i] = xyz_next[i]
                    + XYZ_W'(pix[k*PIX_W +: PIX_W]) * XYZ_W'(FWD_M[i][k]);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            xyz_reg <= xyz_next;
        end
    end

    assign out_valid = valid_reg;
    assign x = xyz_reg[0];
    assign y = xyz_reg[1];
    assign z = xyz_reg[2];

endmodule

`default_nettype wire

/* src/rxls_inv_xform.sv */
// ---------------------------------------------------------------------------
// rxls_inv_xform
// XYZ to RGB matrix: registered products, then sum and saturate.
// ---------------------------------------------------------------------------
`default_nettype none

module rxls_inv_xform (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         adv,
    input  wire logic                         in_valid,
    input  wire logic                         drop,
    input  wire logic [rxls_pkg::RB_W-1:0]    rb_x,
    input  wire logic [rxls_pkg::RB_W-1:0]    rb_y,
    input  wire logic [rxls_pkg::RB_W-1:0]    rb_z,
    output logic                              out_valid,
    output logic [rxls_pkg::TDATA_W-1:0]      pix
);
    import rxls_pkg::*;

    logic                     valid_reg;
    logic                     drop_reg;
    logic signed [PROD_W-1:0] prod_reg  [3][3];
    logic signed [PROD_W-1:0] prod_next [3][3];
    logic [RB_W-1:0]          rb [3];
    logic signed [ACC_W-1:0]  acc [3];
    logic [ACC_W-OUT_SHIFT-1:0] hi [3];

    assign rb[0] = rb_x;
    assign rb[1] = rb_y;
    assign rb[2] = rb_z;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            for (int k = 0; k < 3; k++)
            begin
                prod_next[i][k] = PROD_W'(INV_M[i][k]) * $signed(PROD_W'(rb[k]));
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            prod_reg <= prod_next;
            drop_reg <= drop;
        end
    end

    // sum, truncate, clamp negative to zero and large to full scale; zero when dropped
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            acc[i] = ACC_W'(prod_reg[i][0]) + ACC_W'(prod_reg[i][1])
                   + ACC_W'(prod_reg[i][2]);
            hi[i]  = acc[i][ACC_W-1:OUT_SHIFT];
            if (drop_reg || acc[i][ACC_W-1])
            begin
                pix[i*PIX_W +: PIX_W] = '0;
            end
            else if (hi[i] > (ACC_W-OUT_SHIFT)'(255))
            begin
                pix[i*PIX_W +: PIX_W] = '1;
            end
            else
            begin
                pix[i*PIX_W +: PIX_W] = hi[i][PIX_W-1:0];
            end
        end
    end

    assign out_valid = valid_reg;

endmodule

`default_nettype wire

/* src/rgb_xyy_luminance_scaler.sv */
// ---------------------------------------------------------------------------
// rgb_xyy_luminance_scaler
// RGB -> XYZ -> xyY, luminance gain, xyY -> XYZ -> RGB, fully pipelined.
// ---------------------------------------------------------------------------
//
//  channel   ports                      contents
//  s_*       tvalid tready tdata[23:0]  input pixel, red in [7:0]
//  m_*       tvalid tready tdata[23:0]  scaled pixel, red in [7:0]
//  cfg_*     wr_en wr_data[8:0]         luminance gain, 1/256 units
//
//  One item per clock sustained while the skid register is empty. From
//  acceptance to m_tvalid an item passes the matrix, gain, the two bit-serial
//  divider pipelines (17 and 24 stages), rebuild and output stages.
//  rst_n clears all valid bits and loads the gain with 51.
//  A result that m_tready holds back parks in a skid register; the pipeline
//  and s_tready stall only while that register is full.
//
`default_nettype none
`include "rgb_xyy_luminance_scaler_macros.svh"

module rgb_xyy_luminance_scaler (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         s_tvalid,
    output logic                              s_tready,
    input  wire logic [rxls_pkg::TDATA_W-1:0] s_tdata,   // red_in, green_in, blue_in
    output logic                              m_tvalid,
    input  wire logic                         m_tready,
    output logic [rxls_pkg::TDATA_W-1:0]      m_tdata,   // red_out, green_out, blue_out
    input  wire logic                         cfg_wr_en,
    input  wire logic [rxls_pkg::GAIN_W-1:0]  cfg_wr_data
);
    import rxls_pkg::*;

    // global advance: every stage moves unless the skid register is full
    logic adv;

    logic [GAIN_W-1:0] gain_reg;

    // forward matrix
    logic             fwd_valid;
    logic [XYZ_W-1:0] fx, fy, fz;

    // sum and gain stage
    logic              s2_valid_reg;
    logic [SUM_W-1:0]  sum_reg;
    logic [XYZ_W-1:0]  x2_reg, y2_reg;
    logic [LUMP_W-1:0] lump_reg;
    logic              zero_reg;
    logic [SUM_W-1:0]  sum_next;
    logic [LUMP_W-1:0] lump_next;
    logic [LUMS_W-1:0] lum_s2;

    // chromaticity dividers
    logic               cx_valid, cy_valid;
    logic [CHR_Q_W-1:0] cx_q, cy_q;
    logic [LUMS_W-1:0]  cx_side;
    logic               cy_side;

    // cap, rest, flag stage
    logic              s3_valid_reg;
    logic [CHR_W-1:0]  cx3_reg, cy3_reg;
    logic [REST_W-1:0] rest3_reg;
    logic [LUMS_W-1:0] lum3_reg;
    logic              drop3_reg;
    logic [CHR_W-1:0]  cx_cap, cy_cap;
    logic [CHR_Q_W+1:0] rest_wide;
    logic [REST_W-1:0] rest_next;

    // ratio divider
    localparam int RSIDE_W = CHR_W + REST_W + LUMS_W + 1;
    logic               rt_valid;
    logic [RATIO_W-1:0] ratio;
    logic [RSIDE_W-1:0] rt_side;
    logic [CHR_W-1:0]   cx_r;
    logic [REST_W-1:0]  rest_r;
    logic [LUMS_W-1:0]  lum_r;
    logic               drop_r;

    // rebuild stage
    logic                      s4_valid_reg;
    logic [CHR_W+RATIO_W-1:0]  px_reg;
    logic [REST_W+RATIO_W-1:0] pz_reg;
    logic [LUMS_W-1:0]         lum4_reg;
    logic                      drop4_reg;

    // inverse matrix
    logic               inv_valid;
    logic [TDATA_W-1:0] inv_pix;

    // output register and skid
    logic               out_valid_reg, out_valid_next;
    logic [TDATA_W-1:0] out_data_reg, out_data_next;
    logic               skid_valid_reg, skid_valid_next;
    logic [TDATA_W-1:0] skid_data_reg;

    assign adv      = !skid_valid_reg;
    assign s_tready = adv;

    // gain register; the user must write it only while idle, the block does not enforce this
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_reg <= GAIN_RESET;
        end
        else if (cfg_wr_en)
        begin
            gain_reg <= cfg_wr_data;
        end
    end

    rxls_fwd_xform u_fwd (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (s_tvalid),
        .pix       (s_tdata),
        .out_valid (fwd_valid),
        .x         (fx),
        .y         (fy),
        .z         (fz)
    );

    // X+Y+Z and Y(Q8.8) times gain
    assign sum_next  = SUM_W'(fx) + SUM_W'(fy) + SUM_W'(fz);
    assign lump_next = LUMP_W'(fy[LUM_W+5:6]) * LUMP_W'(gain_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            s2_valid_reg <= fwd_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            sum_reg  <= sum_next;
            x2_reg   <= fx;
            y2_reg   <= fy;
            lump_reg <= lump_next;
            zero_reg <= (sum_next == '0);
        end
    end

    assign lum_s2 = lump_reg[LUMP_W-1:8];

    rxls_pipe_div #(
        .NUM_W  (XYZ_W + 16),
        .DEN_W  (SUM_W),
        .Q_W    (CHR_Q_W),
        .SIDE_W (LUMS_W)
    ) u_div_cx (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (s2_valid_reg),
        .num       ({x2_reg, 16'd0}),
        .den       (sum_reg),
        .side_in   (lum_s2),
        .out_valid (cx_valid),
        .quo       (cx_q),
        .side_out  (cx_side)
    );

    rxls_pipe_div #(
        .NUM_W  (XYZ_W + 16),
        .DEN_W  (SUM_W),
        .Q_W    (CHR_Q_W),
        .SIDE_W (1)
    ) u_div_cy (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (s2_valid_reg),
        .num       ({y2_reg, 16'd0}),
        .den       (sum_reg),
        .side_in   (zero_reg),
        .out_valid (cy_valid),
        .quo       (cy_q),
        .side_out  (cy_side)
    );

    // cap at 65535, form 1 - x - y clamped at zero
    assign cx_cap    = cx_q[CHR_Q_W-1] ? '1 : cx_q[CHR_W-1:0];
    assign cy_cap    = cy_q[CHR_Q_W-1] ? '1 : cy_q[CHR_W-1:0];
    assign rest_wide = (CHR_Q_W+2)'(65536) - (CHR_Q_W+2)'(cx_cap) - (CHR_Q_W+2)'(cy_cap);
    assign rest_next = rest_wide[CHR_Q_W+1] ? '0 : rest_wide[REST_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s3_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            s3_valid_reg <= cx_valid & cy_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            cx3_reg   <= cx_cap;
            cy3_reg   <= cy_cap;
            rest3_reg <= rest_next;
            lum3_reg  <= cx_side;
            drop3_reg <= cy_side || (cy_cap == '0);
        end
    end

    // scaled Y over y; y stays above 2^11 for any non-black pixel
    rxls_pipe_div #(
        .NUM_W  (LUMS_W + 16),
        .DEN_W  (CHR_W),
        .Q_W    (RATIO_W),
        .SIDE_W (RSIDE_W)
    ) u_div_ratio (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (s3_valid_reg),
        .num       ({lum3_reg, 16'd0}),
        .den       (cy3_reg),
        .side_in   ({cx3_reg, rest3_reg, lum3_reg, drop3_reg}),
        .out_valid (rt_valid),
        .quo       (ratio),
        .side_out  (rt_side)
    );

    assign {cx_r, rest_r, lum_r, drop_r} = rt_side;

    // rebuild X and Z
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s4_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            s4_valid_reg <= rt_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            px_reg    <= (CHR_W+RATIO_W)'(cx_r) * (CHR_W+RATIO_W)'(ratio);
            pz_reg    <= (REST_W+RATIO_W)'(rest_r) * (REST_W+RATIO_W)'(ratio);
            lum4_reg  <= lum_r;
            drop4_reg <= drop_r;
        end
    end

    rxls_inv_xform u_inv (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (s4_valid_reg),
        .drop      (drop4_reg),
        .rb_x      (RB_W'(px_reg[CHR_W+RATIO_W-1:16])),
        .rb_y      (RB_W'(lum4_reg)),
        .rb_z      (RB_W'(pz_reg[REST_W+RATIO_W-1:16])),
        .out_valid (inv_valid),
        .pix       (inv_pix)
    );

    // output register with skid: refill from skid first, park when blocked
    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_data_next   = out_data_reg;
        skid_valid_next = skid_valid_reg;
        if (!out_valid_reg || m_tready)
        begin
            if (skid_valid_reg)
            begin
                out_valid_next  = 1'b1;
                out_data_next   = skid_data_reg;
                skid_valid_next = 1'b0;
            end
            else
            begin
                out_valid_next = inv_valid;
                out_data_next  = inv_pix;
            end
        end
        else if (inv_valid && adv)
        begin
            skid_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
        if (!skid_valid_reg)
        begin
            skid_data_reg <= inv_pix;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    // a parked item always sits behind a valid output
    `RXLS_ASSERT_IMP(a_skid_behind_out, skid_valid_reg, out_valid_reg)
    // the input side stalls while an item is parked
    `RXLS_ASSERT_IMP(a_skid_stalls_in, skid_valid_reg, !s_tready)
    // a finished item meeting a blocked output is parked, not lost
    `RXLS_ASSERT_NXT(a_park_on_block,
        out_valid_reg && !m_tready && !skid_valid_reg && inv_valid, skid_valid_reg)

endmodule

`default_nettype wire

/* tb/sv/tb.sv */
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb
// Self-checking bench for the RGB / xyY luminance scaler: directed pixels
// and random pixels under several gain settings and idling phases, each
// result checked against an in-bench fixed-point pixel predictor.
// ---------------------------------------------------------------------------
`default_nettype none

module tb;
    import rxls_pkg::*;

    localparam int HALF_PERIOD  = 5;
    localparam int DRAIN_CYCLES = 80;      // wait longer than the pipeline latency
    localparam int CYCLE_LIMIT  = 400000;
    localparam int N_DIRECTED   = 16;
    localparam int N_PHASES     = 4;

    typedef struct packed {
        logic [7:0] blue;
        logic [7:0] green;
        logic [7:0] red;
    } pixel_t;

    // Forward and inverse matrices, Q2.14.
    localparam longint FWD [9] = '{6757, 5859, 2957, 3483, 11718, 1183, 316, 1953, 15573};
    localparam longint INV [9] = '{53092, -25184, -8167, -15881, 30736, 682,
                                   911, -3342, 17321};

    logic                 clk;
    logic                 rst_n;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [TDATA_W-1:0]   s_tdata;     // red_in, green_in, blue_in
    logic                 m_tvalid;
    logic                 m_tready;
    logic [TDATA_W-1:0]   m_tdata;     // red_out, green_out, blue_out
    logic                 cfg_wr_en;
    logic [GAIN_W-1:0]    cfg_wr_data;

    logic [GAIN_W-1:0]    gain_model;
    pixel_t               pending_pixels[$];
    int                   mismatch_count;
    int                   pixels_sent;
    int                   pixels_checked;
    longint               cycle_count;
    int                   send_idle_pct;
    int                   recv_stall_pct;

    rgb_xyy_luminance_scaler dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_wr_data(cfg_wr_data)
    );

    always #HALF_PERIOD clk = ~clk;

    // Saturate a signed Q.22 channel sum to a byte.
    function automatic logic [7:0] clamp_channel(longint acc);
        longint v;
        if (acc < 0)
            return 8'd0;
        v = acc >>> OUT_SHIFT;
        return (v > 255) ? 8'd255 : v[7:0];
    endfunction

    // Predict the scaled pixel for one input pixel under the given gain.
    function automatic pixel_t scale_luminance(pixel_t p, logic [GAIN_W-1:0] gain);
        longint ch [3];
        longint xyz [3];
        longint rb [3];
        longint acc [3];
        longint total, cx, cy, lum, lum_s, ratio, rest;
        pixel_t res;
        ch[0] = p.red;
        ch[1] = p.green;
        ch[2] = p.blue;
        res = '0;
        for (int i = 0; i < 3; i++)
            xyz[i] = FWD[3*i]*ch[0] + FWD[3*i+1]*ch[1] + FWD[3*i+2]*ch[2];
        total = xyz[0] + xyz[1] + xyz[2];
        if (total == 0)
            return res;
        cx = (xyz[0] << 16) / total;
        cy = (xyz[1] << 16) / total;
        if (cx > 65535) cx = 65535;
        if (cy > 65535) cy = 65535;
        if (cy == 0)
            return res;
        lum   = xyz[1] >> 6;
        lum_s = (lum * gain) >> 8;
        ratio = (lum_s << 16) / cy;
        rest  = 65536 - cx - cy;
        if (rest < 0) rest = 0;
        rb[0] = (cx * ratio) >> 16;
        rb[1] = lum_s;
        rb[2] = (rest * ratio) >> 16;
        for (int i = 0; i < 3; i++)
            acc[i] = INV[3*i]*rb[0] + INV[3*i+1]*rb[1] + INV[3*i+2]*rb[2];
        res.red   = clamp_channel(acc[0]);
        res.green = clamp_channel(acc[1]);
        res.blue  = clamp_channel(acc[2]);
        return res;
    endfunction

    // Hand one pixel to the block; hold tvalid until the handshake and leave
    // it high, so the next pixel can follow without a gap.
    task automatic send_pixel(pixel_t p);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= p;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        pending_pixels.push_back(scale_luminance(p, gain_model));
        pixels_sent++;
        @(negedge clk);
    endtask

    // Write the gain while idle, after draining everything in flight.
    task automatic write_gain(logic [GAIN_W-1:0] g);
        s_tvalid <= 1'b0;
        while (pending_pixels.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= g;
        @(negedge clk);
        cfg_wr_en   <= 1'b0;
        gain_model  = g;
    endtask

    // Receiver: randomly stall, compare each accepted result with the oldest
    // prediction.
    always @(negedge clk)
    begin
        if (rst_n)
            m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge clk)
    begin
        pixel_t got, want;
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("tb NOT OK");
            $finish;
        end
        if (rst_n && m_tvalid && m_tready)
        begin
            got = m_tdata;
            if (pending_pixels.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("unexpected result %h", got);
            end
            else
            begin
                want = pending_pixels.pop_front();
                pixels_checked++;
                if (got !== want)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("mismatch r/g/b exp %0d %0d %0d got %0d %0d %0d",
                                 want.red, want.green, want.blue,
                                 got.red, got.green, got.blue);
                end
            end
        end
    end

    // Directed pixels: extremes, primaries, greys. Black must give black.
    pixel_t directed_pixels [N_DIRECTED] = '{
        '{8'd0,   8'd0,   8'd0},   '{8'd255, 8'd255, 8'd255},
        '{8'd0,   8'd0,   8'd255}, '{8'd0,   8'd255, 8'd0},
        '{8'd255, 8'd0,   8'd0},   '{8'd1,   8'd1,   8'd1},
        '{8'd0,   8'd0,   8'd1},   '{8'd1,   8'd0,   8'd0},
        '{8'd128, 8'd128, 8'd128}, '{8'd170, 8'd85,  8'd170},
        '{8'd85,  8'd170, 8'd85},  '{8'd255, 8'd255, 8'd0},
        '{8'd0,   8'd255, 8'd255}, '{8'd255, 8'd0,   8'd255},
        '{8'd127, 8'd64,  8'd200}, '{8'd254, 8'd1,   8'd128}
    };

    logic [GAIN_W-1:0] gain_steps [5] = '{9'd256, 9'd0, 9'd511, 9'd128, 9'd51};
    int idle_table  [N_PHASES] = '{0, 81, 0, 15};
    int stall_table [N_PHASES] = '{0, 0, 81, 15};

    initial
    begin
        pixel_t p;
        clk            = 1'b0;
        rst_n          = 1'b0;
        s_tvalid       = 1'b0;
        s_tdata        = '0;
        m_tready       = 1'b0;
        cfg_wr_en      = 1'b0;
        cfg_wr_data    = '0;
        gain_model     = GAIN_RESET;
        mismatch_count = 0;
        pixels_sent    = 0;
        pixels_checked = 0;
        cycle_count    = 0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        repeat (8) @(negedge clk);
        rst_n = 1'b1;

        // Directed table under the reset gain; black checked against zero directly.
        for (int i = 0; i < N_DIRECTED; i++)
        begin
            if (directed_pixels[i] == '0 && scale_luminance(directed_pixels[i], gain_model) != '0)
                mismatch_count++;
            send_pixel(directed_pixels[i]);
        end

        // Gain settings, each swept through the idling phases with random pixels.
        for (int g = 0; g < 5; g++)
        begin
            write_gain(gain_steps[g]);
            if (g < 4)
                send_pixel(directed_pixels[1]);
            for (int ph = 0; ph < N_PHASES; ph++)
            begin
                send_idle_pct  = idle_table[ph];
                recv_stall_pct = stall_table[ph];
                for (int n = 0; n < 44; n++)
                begin
                    p = 24'($urandom);
                    if ($urandom_range(9) == 0)
                        p.green = ($urandom_range(1) != 0) ? 8'd0 : 8'd255;
                    send_pixel(p);
                end
            end
        end
        s_tvalid <= 1'b0;
        recv_stall_pct = 0;

        while (pending_pixels.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);

        $display("sent %0d pixels over 6 gain settings, 4 idling phases; %0d checked",
                 pixels_sent, pixels_checked);
        if (mismatch_count == 0 && pending_pixels.size() == 0)
            $display("tb OK");
        else
            $display("tb NOT OK");
        $finish;
    end
endmodule

`default_nettype wire
